// ===== rtl/owdm_pkg.sv =====
// Shared types, register indexes and the cosine table function for the omni drive mixer.
package owdm_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_FL_ANGLE = 3'd0;
  localparam logic [2:0] REG_FR_ANGLE = 3'd1;
  localparam logic [2:0] REG_BL_ANGLE = 3'd2;
  localparam logic [2:0] REG_BR_ANGLE = 3'd3;
  localparam logic [2:0] REG_REV_MASK = 3'd4;

  localparam real PI_VAL = 3.14159265358979323846;

  // Drive levels for one H-bridge.
  typedef struct packed {
    logic [7:0] duty;
    logic       in_one;
    logic       in_two;
  } bridge_t;

  // Quarter-wave cosine entry k (0..90 degrees), rounded to nearest, scaled by 2^fb.
  function automatic int qcos(input int k, input int fb);
    real r;
    r = $cos(k * PI_VAL / 180.0) * (2.0 ** fb);
    if (k >= 90) begin
      return 0;
    end
    return int'(r);
  endfunction

endpackage

// ===== rtl/owdm_cos_lut.sv =====
// Whole-degree cosine lookup built from a quarter-wave constant table.
module owdm_cos_lut #(
  parameter int FRAC_BITS = 15
) (
  input  logic [8:0]               deg,
  output logic signed [FRAC_BITS+1:0] cos_val
);
  import owdm_pkg::*;

  localparam int CW = FRAC_BITS + 2;

  logic signed [CW-1:0] qrom [0:90];
  logic [8:0]           idx9;
  logic                 neg;
  logic signed [CW-1:0] mag;

  for (genvar g = 0; g <= 90; g++) begin : g_rom
    assign qrom[g] = CW'(qcos(g, FRAC_BITS));
  end

  always_comb begin
    priority if (deg <= 9'd90) begin
      idx9 = deg;
      neg  = 1'b0;
    end else if (deg <= 9'd180) begin
      idx9 = 9'd180 - deg;
      neg  = 1'b1;
    end else if (deg <= 9'd270) begin
      idx9 = deg - 9'd180;
      neg  = 1'b1;
    end else begin
      idx9 = 9'd360 - deg;
      neg  = 1'b0;
    end
    mag     = qrom[idx9[6:0]];
    cos_val = neg ? -mag : mag;
  end

endmodule

// ===== rtl/owdm_div_step.sv =====
// Three quotient bits of the restoring divider used for wheel rescaling.
module owdm_div_step #(
  parameter int NW = 36,
  parameter int RW = 27,
  parameter int HI = 8
) (
  input  logic [NW-1:0] rem_in,
  input  logic [RW-1:0] divisor,
  input  logic [8:0]    quo_in,
  output logic [NW-1:0] rem_out,
  output logic [8:0]    quo_out
);

  logic [NW-1:0] r;
  logic [NW-1:0] t;
  logic [8:0]    q;

  always_comb begin
    r = rem_in;
    q = quo_in;
    for (int i = 0; i < 3; i++) begin
      t = NW'(divisor) << (HI - i);
      if (r >= t) begin
        r = r - t;
        q[HI-i] = 1'b1;
      end
    end
    rem_out = r;
    quo_out = q;
  end

endmodule

// ===== rtl/owdm_bridge.sv =====
// H-bridge duty and direction pins for one wheel value.
module owdm_bridge #(
  parameter int DUTY_MAX = 255
) (
  input  logic signed [9:0] val,
  input  logic              rev,
  input  logic              brk,
  output owdm_pkg::bridge_t drv
);
  import owdm_pkg::*;

  logic [9:0]  mag;
  logic [31:0] sat;

  always_comb begin
    mag = val[9] ? 10'(-val) : 10'(val);
    sat = ({22'd0, mag} > 32'(DUTY_MAX)) ? 32'(DUTY_MAX) : {22'd0, mag};
    if (val == 10'sd0) begin
      drv.duty   = 8'(32'(DUTY_MAX));
      drv.in_one = ~brk;
      drv.in_two = ~brk;
    end else if (val[9]) begin
      drv.duty   = sat[7:0];
      drv.in_one = ~rev;
      drv.in_two = rev;
    end else begin
      drv.duty   = sat[7:0];
      drv.in_one = rev;
      drv.in_two = ~rev;
    end
  end

endmodule

// ===== rtl/omni_wheel_drive_mixer.sv =====
// Four-wheel omni drive mixer: heading/speed/rotation command to four H-bridge outputs.
// Usage: a command (heading, rotation, speed, brake) is a transaction on the in_ channel;
// each command yields exactly one transaction on the out_ channel with duty and direction
// pins for the four wheels. Mounting angles and the reversed-pin mask sit in registers
// on the APB-style port; write them only while no command is in flight.
// The pipeline takes one command every cycle while in_stall is low. Stages: angle wrap,
// cosine lookup, multiply-add, max magnitude, rescale multiply, three divider stages of
// three quotient bits each, bridge outputs.
// Every stage holds its own valid bit and loads when it is empty or when the stage after
// it can move, so empty stages fill up while out_stall is high and in_stall rises only
// once the pipeline is full. Nothing is dropped or repeated under stall.
// Reset (rst_n low, synchronous) empties the pipeline and returns the angles to 45,
// 135, 315 and 225 degrees and the reversed mask to zero.
module omni_wheel_drive_mixer #(
  parameter int COS_FRAC_BITS = 15,
  parameter int DUTY_MAX      = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [8:0]        in_heading_deg,
  input  logic signed [8:0] in_rotation,
  input  logic signed [8:0] in_drive_speed,
  input  logic              in_brake,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_fl_duty,
  output logic              out_fl_in_one,
  output logic              out_fl_in_two,
  output logic [7:0]        out_fr_duty,
  output logic              out_fr_in_one,
  output logic              out_fr_in_two,
  output logic [7:0]        out_bl_duty,
  output logic              out_bl_in_one,
  output logic              out_bl_in_two,
  output logic [7:0]        out_br_duty,
  output logic              out_br_in_one,
  output logic              out_br_in_two,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [owdm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import owdm_pkg::*;

  localparam int FB = COS_FRAC_BITS;
  localparam int CW = FB + 2;
  localparam int RW = FB + 12;
  localparam int NW = RW + 9;

  // Configuration registers.
  logic [8:0] angle_r [4];
  logic [3:0] rev_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r[0] <= 9'd45;
      angle_r[1] <= 9'd135;
      angle_r[2] <= 9'd315;
      angle_r[3] <= 9'd225;
      rev_r      <= 4'd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_FL_ANGLE: angle_r[0] <= pwdata[8:0];
        REG_FR_ANGLE: angle_r[1] <= pwdata[8:0];
        REG_BL_ANGLE: angle_r[2] <= pwdata[8:0];
        REG_BR_ANGLE: angle_r[3] <= pwdata[8:0];
        REG_REV_MASK: rev_r      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FL_ANGLE: prdata = {23'd0, angle_r[0]};
      REG_FR_ANGLE: prdata = {23'd0, angle_r[1]};
      REG_BL_ANGLE: prdata = {23'd0, angle_r[2]};
      REG_BR_ANGLE: prdata = {23'd0, angle_r[3]};
      REG_REV_MASK: prdata = {28'd0, rev_r};
      default:      prdata = 32'd0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or the next stage loads.
  logic [8:1] v_r;
  logic [9:1] en;
  logic       out_valid_r;

  always_comb begin
    en[9] = ~out_valid_r | ~out_stall;
    for (int k = 8; k >= 1; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  assign in_stall = ~en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
      if (en[9]) out_valid_r <= v_r[8];
    end
  end

  // Command fields that travel alongside the data.
  logic signed [8:0] sp_r  [1:8];
  logic signed [8:0] rot_r [1:8];
  logic              brk_r [1:8];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sp_r[1]  <= in_drive_speed;
      rot_r[1] <= in_rotation;
      brk_r[1] <= in_brake;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        sp_r[k]  <= sp_r[k-1];
        rot_r[k] <= rot_r[k-1];
        brk_r[k] <= brk_r[k-1];
      end
    end
  end

  // Stage 1: wheel angle + 90 - heading, wrapped into 0..359.
  logic [10:0] dsum [4];
  logic [8:0]  dwrap [4];
  logic [8:0]  deg_r [4];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      dsum[w] = 11'(angle_r[w]) + 11'd810 - 11'(in_heading_deg);
      priority if (dsum[w] >= 11'd1080) dwrap[w] = 9'(dsum[w] - 11'd1080);
      else if (dsum[w] >= 11'd720)      dwrap[w] = 9'(dsum[w] - 11'd720);
      else if (dsum[w] >= 11'd360)      dwrap[w] = 9'(dsum[w] - 11'd360);
      else                              dwrap[w] = 9'(dsum[w]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) deg_r <= dwrap;
  end

  // Stage 2: cosine lookup.
  logic signed [CW-1:0] cos_c [4];
  logic signed [CW-1:0] cos_r [4];

  for (genvar w = 0; w < 4; w++) begin : g_cos
    owdm_cos_lut #(.FRAC_BITS(FB)) u_lut (
      .deg     (deg_r[w]),
      .cos_val (cos_c[w])
    );
  end

  always_ff @(posedge clk) begin
    if (en[2]) cos_r <= cos_c;
  end

  // Stage 3: raw = speed * cos + rotation scaled.
  logic signed [RW-1:0] raw_c [4];
  logic signed [RW-1:0] raw3_r [4];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      raw_c[w] = RW'(sp_r[2]) * RW'(cos_r[w]) + (RW'(rot_r[2]) <<< FB);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) raw3_r <= raw_c;
  end

  // Stage 4: largest magnitude.
  logic [RW-1:0]        mag_c [4];
  logic [RW-1:0]        max_c;
  logic signed [RW-1:0] raw4_r [4];
  logic [RW-1:0]        max4_r;

  always_comb begin
    max_c = '0;
    for (int w = 0; w < 4; w++) begin
      mag_c[w] = raw3_r[w][RW-1] ? RW'(-raw3_r[w]) : RW'(raw3_r[w]);
      if (mag_c[w] > max_c) max_c = mag_c[w];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      raw4_r <= raw3_r;
      max4_r <= max_c;
    end
  end

  // Stage 5: dividend |raw * speed| and result sign.
  logic [8:0]    spmag;
  logic [NW-1:0] num_c [4];
  logic [NW-1:0] rem_r [5:8][4];
  logic [8:0]    quo_r [5:8][4];
  logic          neg_r [5:8][4];
  logic [RW-1:0] dvs_r [5:8];

  always_comb begin
    spmag = sp_r[4][8] ? 9'(-sp_r[4]) : 9'(sp_r[4]);
    for (int w = 0; w < 4; w++) begin
      num_c[w] = NW'(raw4_r[w][RW-1] ? RW'(-raw4_r[w]) : RW'(raw4_r[w])) * NW'(spmag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dvs_r[5] <= max4_r;
      for (int w = 0; w < 4; w++) begin
        rem_r[5][w] <= num_c[w];
        quo_r[5][w] <= 9'd0;
        neg_r[5][w] <= raw4_r[w][RW-1] ^ sp_r[4][8];
      end
    end
  end

  // Stages 6 to 8: quotient bits 8..6, 5..3, 2..0.
  logic [NW-1:0] rem_c [6:8][4];
  logic [8:0]    quo_c [6:8][4];

  for (genvar s = 6; s <= 8; s++) begin : g_div
    for (genvar w = 0; w < 4; w++) begin : g_wheel
      owdm_div_step #(.NW(NW), .RW(RW), .HI(8 - 3 * (s - 6))) u_step (
        .rem_in  (rem_r[s-1][w]),
        .divisor (dvs_r[s-1]),
        .quo_in  (quo_r[s-1][w]),
        .rem_out (rem_c[s][w]),
        .quo_out (quo_c[s][w])
      );
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        dvs_r[s] <= dvs_r[s-1];
        for (int w = 0; w < 4; w++) begin
          rem_r[s][w] <= rem_c[s][w];
          quo_r[s][w] <= quo_c[s][w];
          neg_r[s][w] <= neg_r[s-1][w];
        end
      end
    end
  end

  // Output stage: pick wheel value and drive the bridges.
  logic signed [9:0] val_c [4];
  bridge_t           drv_c [4];
  bridge_t           drv_r [4];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      if (sp_r[8] == 9'sd0) begin
        val_c[w] = 10'(rot_r[8]);
      end else if (dvs_r[8] == '0) begin
        val_c[w] = 10'sd0;
      end else if (neg_r[8][w]) begin
        val_c[w] = -$signed({1'b0, quo_r[8][w]});
      end else begin
        val_c[w] = $signed({1'b0, quo_r[8][w]});
      end
    end
  end

  for (genvar w = 0; w < 4; w++) begin : g_br
    owdm_bridge #(.DUTY_MAX(DUTY_MAX)) u_bridge (
      .val (val_c[w]),
      .rev (rev_r[w]),
      .brk (brk_r[8]),
      .drv (drv_c[w])
    );
  end

  always_ff @(posedge clk) begin
    if (en[9]) drv_r <= drv_c;
  end

  assign out_valid     = out_valid_r;
  assign out_fl_duty   = drv_r[0].duty;
  assign out_fl_in_one = drv_r[0].in_one;
  assign out_fl_in_two = drv_r[0].in_two;
  assign out_fr_duty   = drv_r[1].duty;
  assign out_fr_in_one = drv_r[1].in_one;
  assign out_fr_in_two = drv_r[1].in_two;
  assign out_bl_duty   = drv_r[2].duty;
  assign out_bl_in_one = drv_r[2].in_one;
  assign out_bl_in_two = drv_r[2].in_two;
  assign out_br_duty   = drv_r[3].duty;
  assign out_br_in_one = drv_r[3].in_one;
  assign out_br_in_two = drv_r[3].in_two;

endmodule
